// ===== rtl/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfc_pkg: shared types and constants of the line fit chi-square core
// Holds status codes, sequencer step codes, the controller/datapath command
// and status groups, and the saturation helper used by the datapath.
// ----------------------------------------------------------------------------
package lfc_pkg;

	localparam int DEF_MAX_POINTS = 1024;
	localparam int TWO_DOF        = 2;
	localparam int OP_W           = 64;   // operand width of the shared multiplier
	localparam int DIV_W          = 128;  // width of the shared divider

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_SINGULAR = 3'd1,
		STAT_ZERO_ERR = 3'd2,
		STAT_FEW      = 3'd3,
		STAT_OVERFLOW = 3'd4
	} lfc_status_t;

	typedef enum logic [3:0] {
		ST_M1     = 4'd0,   // n * Sxx
		ST_M2     = 4'd1,   // Sx * Sx
		ST_M3     = 4'd2,   // n * Sxy
		ST_M4     = 4'd3,   // Sx * Sy
		ST_M5     = 4'd4,   // Sxx * Sy
		ST_M6     = 4'd5,   // Sxy * Sx
		ST_EE     = 4'd6,   // e * e
		ST_RR     = 4'd7,   // r * r
		ST_DSLOPE = 4'd8,
		ST_DICEPT = 4'd9,
		ST_DTERM  = 4'd10,
		ST_DRED   = 4'd11
	} lfc_step_t;

	typedef struct packed {
		logic        load;
		logic        clr_work;
		logic        mul_start;
		logic        div_start;
		logic        capture;
		logic        rd;
		logic        pt_mul;
		logic        pt_fit;
		logic        idx_clr;
		logic        idx_inc;
		logic        result;
		logic        clear_set;
		lfc_step_t   step;
		lfc_status_t stat;
	} lfc_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic overflow;
		logic few_points;
		logic d_nonpos;
		logic den_zero;
		logic last_idx;
	} lfc_sts_t;

	// Saturate a quotient magnitude with sign to the signed 32-bit range.
	function automatic logic [31:0] sat_s32(input logic [DIV_W-1:0] q, input logic neg);
		logic [31:0] r;
		if (!neg) begin
			r = (q > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
		end else begin
			r = (q > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
		end
		return r;
	endfunction

endpackage

// ===== rtl/lfc_ifs.sv =====
// ----------------------------------------------------------------------------
// lfc_ifs: request channels of the line fit chi-square core
// Point channel (input items) and fit channel (result items), valid/ready.
// ----------------------------------------------------------------------------
interface lfc_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic        [31:0] x_error;
	logic        [31:0] y_error;
	logic               last_point;

	modport source (output valid, x_value, y_value, x_error, y_error, last_point,
		input ready);
	modport sink (input valid, x_value, y_value, x_error, y_error, last_point,
		output ready);
endinterface

interface lfc_fit_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] slope;
	logic signed [31:0] intercept;
	logic        [31:0] chi_square;
	logic        [31:0] reduced_chi_square;
	logic        [2:0]  status;

	modport source (output valid, slope, intercept, chi_square, reduced_chi_square,
		status, input ready);
	modport sink (input valid, slope, intercept, chi_square, reduced_chi_square,
		status, output ready);
endinterface

// ===== rtl/lfc_mul_unit.sv =====
// ----------------------------------------------------------------------------
// lfc_mul_unit: shift-add signed multiplier, 64 x 64 -> 128
// One multiplier bit per cycle on magnitudes, sign applied in a final cycle.
// ----------------------------------------------------------------------------
module lfc_mul_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [lfc_pkg::OP_W-1:0]     a,
	input  logic signed [lfc_pkg::OP_W-1:0]     b,
	output logic                                done,
	output logic signed [2*lfc_pkg::OP_W-1:0]   prod
);
	localparam int OW   = lfc_pkg::OP_W;
	localparam int CNTW = $clog2(OW);

	logic            run_q, fix_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic            neg_q;
	logic [2*OW-1:0] mcand_q;
	logic [OW-1:0]   mplier_q;
	logic [2*OW-1:0] acc_q;
	logic [OW-1:0]   mag_a, mag_b;

	assign mag_a = a[OW-1] ? (~a + OW'(1)) : a;
	assign mag_b = b[OW-1] ? (~b + OW'(1)) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(OW - 1)) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				fix_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= {{OW{1'b0}}, mag_a};
			mplier_q <= mag_b;
			acc_q    <= '0;
			neg_q    <= a[OW-1] ^ b[OW-1];
		end else if (run_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[2*OW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[OW-1:1]};
		end else if (fix_q) begin
			if (neg_q) begin
				acc_q <= ~acc_q + (2*OW)'(1);
			end
		end
	end

	assign done = done_q;
	assign prod = $signed(acc_q);
endmodule

// ===== rtl/lfc_div_unit.sv =====
// ----------------------------------------------------------------------------
// lfc_div_unit: restoring divider, 128 / 128 unsigned
// One quotient bit per cycle; the divisor stays below 2^127.
// ----------------------------------------------------------------------------
module lfc_div_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [lfc_pkg::DIV_W-1:0]     num,
	input  logic [lfc_pkg::DIV_W-1:0]     den,
	output logic                          done,
	output logic [lfc_pkg::DIV_W-1:0]     quo
);
	localparam int DW   = lfc_pkg::DIV_W;
	localparam int CNTW = $clog2(DW);

	logic            run_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q, quo_q, den_q;
	logic [DW-1:0]   rem_sh;
	logic [DW:0]     diff;

	assign rem_sh = {rem_q[DW-2:0], quo_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNTW'(1);
				if (cnt_q == CNTW'(DW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (run_q) begin
			rem_q <= diff[DW] ? rem_sh : diff[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ~diff[DW]};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

// ===== rtl/lfc_datapath.sv =====
// ----------------------------------------------------------------------------
// lfc_datapath: point store, running sums and fit arithmetic
// Executes the controller's commands with one shared multiplier and divider.
// ----------------------------------------------------------------------------
module lfc_datapath #(
	parameter int MAX_POINTS = lfc_pkg::DEF_MAX_POINTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lfc_pkg::lfc_cmd_t  cmd,
	output lfc_pkg::lfc_sts_t  sts,
	input  logic               in_valid,
	input  logic signed [31:0] x_value,
	input  logic signed [31:0] y_value,
	input  logic        [31:0] x_error,
	input  logic        [31:0] y_error,
	output logic signed [31:0] slope,
	output logic signed [31:0] intercept,
	output logic        [31:0] chi_square,
	output logic        [31:0] reduced_chi_square,
	output logic        [2:0]  status
);
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int OW = lfc_pkg::OP_W;
	localparam int DW = lfc_pkg::DIV_W;

	// point store: {x, y, x error, y error}
	logic [127:0] mem [MAX_POINTS];
	logic [127:0] rd_q;
	logic [AW-1:0] idx_q;

	logic [CW-1:0]       count_q;
	logic signed [63:0]  sx_q, sy_q, sxx_q, sxy_q;
	logic                ovf_q;

	logic signed [DW-1:0] tmp_q, d_q, p_q, q_q;
	logic signed [31:0]   slope_q, icept_q;
	logic [63:0]          acc_q;
	logic [31:0]          chi_q, red_q;
	logic signed [63:0]   xp_q, diff_q;
	logic [63:0]          xep_q, yy_q, e_q;
	logic [DW-1:0]        den_q;
	logic                 div_neg_q;

	logic signed [31:0] out_slope_q, out_icept_q;
	logic [31:0]        out_chi_q, out_red_q;
	logic [2:0]         out_stat_q;

	logic               load_fire, room;
	logic signed [63:0] xx, xy;
	logic signed [31:0] rx, ry;
	logic [31:0]        rxe, rye, abs_slope;

	logic                 mul_start, mul_done;
	logic signed [OW-1:0] mul_a, mul_b;
	logic signed [DW-1:0] mprod;
	logic                 div_done, div_neg;
	logic [DW-1:0]        div_num, div_den, sig_num, quo;
	logic [63:0]          term;
	logic [64:0]          acc_sum;

	assign load_fire = cmd.load && in_valid;
	assign room      = count_q < CW'(MAX_POINTS);
	assign xx        = x_value * x_value;
	assign xy        = x_value * y_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			sxy_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear_set) begin
			count_q <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			sxx_q   <= '0;
			sxy_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (load_fire) begin
			if (room) begin
				count_q <= count_q + CW'(1);
				sx_q    <= sx_q + x_value;
				sy_q    <= sy_q + y_value;
				sxx_q   <= sxx_q + (xx >>> 16);
				sxy_q   <= sxy_q + (xy >>> 16);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_fire && room) begin
			mem[count_q[AW-1:0]] <= {x_value, y_value, x_error, y_error};
		end
		if (cmd.rd) begin
			rd_q <= mem[idx_q];
		end
	end

	assign rx        = $signed(rd_q[127:96]);
	assign ry        = $signed(rd_q[95:64]);
	assign rxe       = rd_q[63:32];
	assign rye       = rd_q[31:0];
	assign abs_slope = slope_q[31] ? (~slope_q + 32'd1) : slope_q;

	// multiplier operands by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.step)
			lfc_pkg::ST_M1: begin mul_a = $signed(OW'(count_q)); mul_b = sxx_q; end
			lfc_pkg::ST_M2: begin mul_a = sx_q;  mul_b = sx_q; end
			lfc_pkg::ST_M3: begin mul_a = $signed(OW'(count_q)); mul_b = sxy_q; end
			lfc_pkg::ST_M4: begin mul_a = sx_q;  mul_b = sy_q; end
			lfc_pkg::ST_M5: begin mul_a = sxx_q; mul_b = sy_q; end
			lfc_pkg::ST_M6: begin mul_a = sxy_q; mul_b = sx_q; end
			lfc_pkg::ST_EE: begin mul_a = $signed(e_q); mul_b = $signed(e_q); end
			lfc_pkg::ST_RR: begin mul_a = diff_q; mul_b = diff_q; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// divider operands by step; signed numerators go in as magnitudes
	always_comb begin
		sig_num = '0;
		div_den = '0;
		div_neg = 1'b0;
		unique case (cmd.step)
			lfc_pkg::ST_DSLOPE: begin
				sig_num = p_q <<< 16;
				div_den = d_q;
				div_neg = sig_num[DW-1];
			end
			lfc_pkg::ST_DICEPT: begin
				sig_num = q_q <<< 16;
				div_den = d_q;
				div_neg = sig_num[DW-1];
			end
			lfc_pkg::ST_DTERM: begin
				sig_num = tmp_q << 16;
				div_den = den_q;
			end
			lfc_pkg::ST_DRED: begin
				sig_num = DW'(acc_q);
				div_den = DW'(count_q - CW'(lfc_pkg::TWO_DOF));
			end
			default: begin
				sig_num = '0;
				div_den = '0;
			end
		endcase
		div_num = div_neg ? (~sig_num + DW'(1)) : sig_num;
	end

	assign mul_start = cmd.mul_start;

	lfc_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mprod)
	);

	lfc_div_unit u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	assign term    = (|quo[DW-1:64]) ? '1 : quo[63:0];
	assign acc_sum = {1'b0, acc_q} + {1'b0, term};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_neg_q <= div_neg;
		end
		if (cmd.clr_work) begin
			slope_q <= '0;
			icept_q <= '0;
			acc_q   <= '0;
			chi_q   <= '0;
			red_q   <= '0;
		end
		if (cmd.pt_mul) begin
			xp_q  <= rx * slope_q;
			xep_q <= 64'(rxe) * 64'(abs_slope);
			yy_q  <= 64'(rye) * 64'(rye);
		end
		if (cmd.pt_fit) begin
			diff_q <= ry - (xp_q >>> 16) - icept_q;
			e_q    <= xep_q >> 16;
		end
		if (cmd.capture) begin
			unique case (cmd.step)
				lfc_pkg::ST_M1, lfc_pkg::ST_M3, lfc_pkg::ST_M5, lfc_pkg::ST_RR: tmp_q <= mprod;
				lfc_pkg::ST_M2: d_q <= (tmp_q <<< 16) - mprod;
				lfc_pkg::ST_M4: p_q <= (tmp_q <<< 16) - mprod;
				lfc_pkg::ST_M6: q_q <= tmp_q - mprod;
				lfc_pkg::ST_EE: den_q <= mprod + DW'(yy_q);
				lfc_pkg::ST_DSLOPE: slope_q <= lfc_pkg::sat_s32(quo, div_neg_q);
				lfc_pkg::ST_DICEPT: icept_q <= lfc_pkg::sat_s32(quo, div_neg_q);
				lfc_pkg::ST_DTERM: acc_q <= acc_sum[64] ? '1 : acc_sum[63:0];
				lfc_pkg::ST_DRED: begin
					chi_q <= (|acc_q[63:32]) ? '1 : acc_q[31:0];
					red_q <= (|quo[DW-1:32]) ? '1 : quo[31:0];
				end
				default: tmp_q <= tmp_q;
			endcase
		end
		if (cmd.result) begin
			out_slope_q <= slope_q;
			out_icept_q <= icept_q;
			out_chi_q   <= chi_q;
			out_red_q   <= red_q;
			out_stat_q  <= cmd.stat;
		end
	end

	always_comb begin
		sts.mul_done   = mul_done;
		sts.div_done   = div_done;
		sts.overflow   = ovf_q;
		sts.few_points = count_q < CW'(3);
		sts.d_nonpos   = d_q[DW-1] || (d_q == '0);
		sts.den_zero   = den_q == '0;
		sts.last_idx   = CW'(idx_q) == (count_q - CW'(1));
	end

	assign slope              = out_slope_q;
	assign intercept          = out_icept_q;
	assign chi_square         = out_chi_q;
	assign reduced_chi_square = out_red_q;
	assign status             = out_stat_q;
endmodule

// ===== rtl/lfc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfc_ctrl: sequencer of the line fit chi-square core
// Loads points, then walks the solve, the residual pass and the result.
// ----------------------------------------------------------------------------
module lfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output lfc_pkg::lfc_cmd_t cmd,
	input  lfc_pkg::lfc_sts_t sts
);
	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_CHECK    = 12'b0000_0000_0010,
		S_TEST_D   = 12'b0000_0000_0100,
		S_MUL_GO   = 12'b0000_0000_1000,
		S_MUL_WAIT = 12'b0000_0001_0000,
		S_DIV_GO   = 12'b0000_0010_0000,
		S_DIV_WAIT = 12'b0000_0100_0000,
		S_RD       = 12'b0000_1000_0000,
		S_PT1      = 12'b0001_0000_0000,
		S_PT2      = 12'b0010_0000_0000,
		S_TEST_DEN = 12'b0100_0000_0000,
		S_RESULT   = 12'b1000_0000_0000
	} lfc_state_t;

	lfc_state_t           state_q, state_d;
	lfc_pkg::lfc_step_t   step_q, step_d;
	lfc_pkg::lfc_status_t stat_q, stat_d;
	logic                 out_valid_q;

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		stat_d   = stat_q;
		cmd      = '0;
		cmd.step = step_q;
		cmd.stat = stat_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = 1'b1;
				if (in_valid && in_last) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.clr_work = 1'b1;
				stat_d       = lfc_pkg::STAT_OK;
				if (sts.overflow) begin
					stat_d  = lfc_pkg::STAT_OVERFLOW;
					state_d = S_RESULT;
				end else if (sts.few_points) begin
					stat_d  = lfc_pkg::STAT_FEW;
					state_d = S_RESULT;
				end else begin
					step_d  = lfc_pkg::ST_M1;
					state_d = S_MUL_GO;
				end
			end
			S_TEST_D: begin
				if (sts.d_nonpos) begin
					stat_d  = lfc_pkg::STAT_SINGULAR;
					state_d = S_RESULT;
				end else begin
					step_d  = lfc_pkg::ST_M3;
					state_d = S_MUL_GO;
				end
			end
			S_MUL_GO: begin
				cmd.mul_start = 1'b1;
				state_d       = S_MUL_WAIT;
			end
			S_MUL_WAIT: begin
				if (sts.mul_done) begin
					cmd.capture = 1'b1;
					state_d     = S_MUL_GO;
					unique case (step_q)
						lfc_pkg::ST_M1: step_d = lfc_pkg::ST_M2;
						lfc_pkg::ST_M2: state_d = S_TEST_D;
						lfc_pkg::ST_M3: step_d = lfc_pkg::ST_M4;
						lfc_pkg::ST_M4: step_d = lfc_pkg::ST_M5;
						lfc_pkg::ST_M5: step_d = lfc_pkg::ST_M6;
						lfc_pkg::ST_M6: begin
							step_d  = lfc_pkg::ST_DSLOPE;
							state_d = S_DIV_GO;
						end
						lfc_pkg::ST_EE: state_d = S_TEST_DEN;
						lfc_pkg::ST_RR: begin
							step_d  = lfc_pkg::ST_DTERM;
							state_d = S_DIV_GO;
						end
						default: state_d = S_RESULT;
					endcase
				end
			end
			S_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_WAIT;
			end
			S_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.capture = 1'b1;
					unique case (step_q)
						lfc_pkg::ST_DSLOPE: begin
							step_d  = lfc_pkg::ST_DICEPT;
							state_d = S_DIV_GO;
						end
						lfc_pkg::ST_DICEPT: begin
							cmd.idx_clr = 1'b1;
							state_d     = S_RD;
						end
						lfc_pkg::ST_DTERM: begin
							if (sts.last_idx) begin
								step_d  = lfc_pkg::ST_DRED;
								state_d = S_DIV_GO;
							end else begin
								cmd.idx_inc = 1'b1;
								state_d     = S_RD;
							end
						end
						default: state_d = S_RESULT;
					endcase
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_PT1;
			end
			S_PT1: begin
				cmd.pt_mul = 1'b1;
				state_d    = S_PT2;
			end
			S_PT2: begin
				cmd.pt_fit = 1'b1;
				step_d     = lfc_pkg::ST_EE;
				state_d    = S_MUL_GO;
			end
			S_TEST_DEN: begin
				if (sts.den_zero) begin
					stat_d  = lfc_pkg::STAT_ZERO_ERR;
					state_d = S_RESULT;
				end else begin
					step_d  = lfc_pkg::ST_RR;
					state_d = S_MUL_GO;
				end
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.result    = 1'b1;
					cmd.clear_set = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= lfc_pkg::ST_M1;
			stat_q      <= lfc_pkg::STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			stat_q  <= stat_d;
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

// ===== rtl/line_fit_chi_square_core.sv =====
// ----------------------------------------------------------------------------
// line_fit_chi_square_core: least-squares line fit with chi-square
// Stores Q16.16 points, solves slope and intercept on the last point, then
// sums chi-square terms over the stored points and returns one result.
//
//   channel  dir  request                                           when
//   point    in   x_value, y_value, x_error, y_error, last_point    each point
//   fit      out  slope, intercept, chi_square, reduced_chi_square, status
//                                                                   per set
//
// Flow: points that are not last are taken back to back. After a last point
// the core checks the set, then forms each 64 x 64 product on the shift-add
// multiplier and each 128-bit quotient on the restoring divider to solve the
// fit and to sum the terms of every stored point, then posts the result.
// Reset clears the counters, sums and flags; the point store is not cleared.
// Hold off the point channel during the fit; a waiting result stalls only the next post.
// ----------------------------------------------------------------------------
module line_fit_chi_square_core #(
	parameter int MAX_POINTS = lfc_pkg::DEF_MAX_POINTS
) (
	input  logic       clk,
	input  logic       arst_n,
	lfc_point_if.sink  point,
	lfc_fit_if.source  fit
);
	lfc_pkg::lfc_cmd_t cmd;
	lfc_pkg::lfc_sts_t sts;

	// sequencer: owns handshakes and walks the fit steps
	lfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (point.valid),
		.in_last   (point.last_point),
		.in_ready  (point.ready),
		.out_ready (fit.ready),
		.out_valid (fit.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	// datapath: store, sums, shared multiplier and divider, result register
	lfc_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_valid           (point.valid),
		.x_value            (point.x_value),
		.y_value            (point.y_value),
		.x_error            (point.x_error),
		.y_error            (point.y_error),
		.slope              (fit.slope),
		.intercept          (fit.intercept),
		.chi_square         (fit.chi_square),
		.reduced_chi_square (fit.reduced_chi_square),
		.status             (fit.status)
	);
endmodule
